// ===== src/gce_pkg.sv =====
// shared types and constants for the graph connectivity engine
package gce_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int CMD_W      = 2;
    localparam int VERTEX_W   = 6;
    localparam int CNT_W      = 7;
    localparam int EDGE_W     = 12;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED     = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } t_in_item;

    typedef struct packed {
        logic              bad_edge;
        logic              all_reachable;
        logic [CNT_W-1:0]  reached_count;
        logic [CNT_W-1:0]  component_count;
        logic [EDGE_W-1:0] edge_count;
        logic              tree_flag;
        logic              forest_flag;
    } t_out_item;

endpackage

// ===== src/gce_ram.sv =====
// generic simple dual-port ram with registered read
module gce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/graph_connectivity_engine.sv =====
// graph connectivity engine top level: adjacency store, depth-first walk sequencer
//
//  channel   direction  signals                                   item
//  -------   ---------  ----------------------------------------  ----------------------
//  in        sink       i_in_valid, o_in_stall, i_in_item         cmd, vertex_a, vertex_b
//  out       source     o_out_valid, i_out_stall, o_out_item      one result per item
//  cfg       sink       i_cfg_we, i_cfg_index, i_cfg_data         vertex_count, directed
//
//  clear writes one adjacency row per cycle
//  add edge does a read-modify-write of one row, twice when mirrored
//  query scans one adjacency bit per cycle in the reach walk and, in undirected
//  mode, also in the component walk over the active vertices
//  after reset a clearing pass over all MAX_VERTICES rows runs before the first item
//  o_in_stall is high while an item is in work; a new item is taken while the
//  previous result still waits on a stalled output
module graph_connectivity_engine #(
    parameter int MAX_VERTICES = gce_pkg::MAX_VERTICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gce_pkg::t_in_item                i_in_item,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gce_pkg::t_out_item               o_out_item,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [gce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gce_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // vertex index width, vertex count width, edge entry count width
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);
    localparam int SW  = EW + 1;
    localparam int CW  = (NW > gce_pkg::VERTEX_W) ? NW : gce_pkg::VERTEX_W;
    localparam int VCW = (NW > gce_pkg::CNT_W) ? NW : gce_pkg::CNT_W;
    localparam logic [VW-1:0] LAST_ROW = VW'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_RD_B,
        S_ADD_WR_B,
        S_QINIT,
        S_POP,
        S_FETCH,
        S_SCAN,
        S_COMP,
        S_FIN,
        S_OUT
    } t_state;

    // control state
    t_state                       r_state, n_state;
    logic [gce_pkg::CNT_W-1:0]    r_vc;
    logic                         r_dir;
    logic [VW-1:0]                r_clr_addr, n_clr_addr;
    logic                         r_clr_reply, n_clr_reply;
    logic [NW-1:0]                r_sp, n_sp;
    logic [EW-1:0]                r_entries, n_entries;
    logic                         r_comp_phase, n_comp_phase;
    logic                         r_out_valid, n_out_valid;

    // payload and walk datapath
    logic [gce_pkg::VERTEX_W-1:0] r_a, n_a;
    logic [gce_pkg::VERTEX_W-1:0] r_b, n_b;
    logic [MAX_VERTICES-1:0]      r_visited, n_visited;
    logic [VW-1:0]                r_u, n_u;
    logic [VW-1:0]                r_i, n_i;
    logic [NW-1:0]                r_reach, n_reach;
    logic [NW-1:0]                r_comps, n_comps;
    gce_pkg::t_out_item           r_res, n_res;
    gce_pkg::t_out_item           r_out_item, n_out_item;

    // ram ports
    logic                         adj_we, adj_re;
    logic [VW-1:0]                adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0]      adj_wdata, adj_rdata;
    logic                         stk_we, stk_re;
    logic [VW-1:0]                stk_waddr, stk_raddr;
    logic [VW-1:0]                stk_wdata, stk_rdata;

    // derived values
    logic [NW-1:0]                w_n;
    logic [VW-1:0]                w_n_last;
    logic [VCW-1:0]               w_vc_ext;
    logic [VW-1:0]                w_a_v, w_b_v;
    logic                         w_in_bad;
    logic [EW-1:0]                w_edges;

    // active vertex count: zero acts as one, clamp at the store size
    always_comb begin
        w_vc_ext = VCW'(r_vc);
        if (r_vc == '0) begin
            w_n = NW'(1);
        end else if (w_vc_ext > VCW'(MAX_VERTICES)) begin
            w_n = NW'(MAX_VERTICES);
        end else begin
            w_n = NW'(r_vc);
        end
    end

    assign w_n_last = VW'(w_n - 1'b1);
    assign w_a_v    = VW'(r_a);
    assign w_b_v    = VW'(r_b);
    assign w_edges  = r_dir ? r_entries : (r_entries >> 1);

    // self edge or endpoint out of range, checked on the incoming item
    assign w_in_bad = (i_in_item.vertex_a == i_in_item.vertex_b) ||
                      (CW'(i_in_item.vertex_a) >= CW'(w_n)) ||
                      (CW'(i_in_item.vertex_b) >= CW'(w_n));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    gce_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gce_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // sequencer next-state and datapath
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_clr_reply  = r_clr_reply;
        n_sp         = r_sp;
        n_entries    = r_entries;
        n_comp_phase = r_comp_phase;
        n_a          = r_a;
        n_b          = r_b;
        n_visited    = r_visited;
        n_u          = r_u;
        n_i          = r_i;
        n_reach      = r_reach;
        n_comps      = r_comps;
        n_res        = r_res;
        n_out_item   = r_out_item;
        // output register empties when the result is taken
        n_out_valid  = r_out_valid && i_out_stall;

        adj_we    = 1'b0;
        adj_waddr = r_clr_addr;
        adj_wdata = '0;
        adj_re    = 1'b0;
        adj_raddr = w_a_v;
        stk_we    = 1'b0;
        stk_waddr = r_sp[VW-1:0];
        stk_wdata = r_u;
        stk_re    = 1'b0;
        stk_raddr = VW'(r_sp - 1'b1);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a   = i_in_item.vertex_a;
                    n_b   = i_in_item.vertex_b;
                    n_res = '0;
                    case (i_in_item.cmd)
                        gce_pkg::CMD_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        gce_pkg::CMD_ADD: begin
                            if (w_in_bad) begin
                                n_res.bad_edge = 1'b1;
                                n_state        = S_OUT;
                            end else begin
                                n_state = S_ADD_RD_A;
                            end
                        end
                        gce_pkg::CMD_QUERY: begin
                            n_state = S_QINIT;
                        end
                        default: begin
                            // unused code: zero result, no state change
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_CLR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr_addr;
                adj_wdata = '0;
                if (r_clr_addr == LAST_ROW) begin
                    n_entries = '0;
                    n_state   = r_clr_reply ? S_OUT : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end

            S_ADD_RD_A: begin
                adj_re    = 1'b1;
                adj_raddr = w_a_v;
                n_state   = S_ADD_WR_A;
            end

            S_ADD_WR_A: begin
                if (!adj_rdata[w_b_v]) begin
                    adj_we           = 1'b1;
                    adj_waddr        = w_a_v;
                    adj_wdata        = adj_rdata;
                    adj_wdata[w_b_v] = 1'b1;
                    n_entries        = r_entries + 1'b1;
                end
                n_state = r_dir ? S_OUT : S_ADD_RD_B;
            end

            S_ADD_RD_B: begin
                adj_re    = 1'b1;
                adj_raddr = w_b_v;
                n_state   = S_ADD_WR_B;
            end

            S_ADD_WR_B: begin
                if (!adj_rdata[w_a_v]) begin
                    adj_we           = 1'b1;
                    adj_waddr        = w_b_v;
                    adj_wdata        = adj_rdata;
                    adj_wdata[w_a_v] = 1'b1;
                    n_entries        = r_entries + 1'b1;
                end
                n_state = S_OUT;
            end

            S_QINIT: begin
                n_visited    = '0;
                n_reach      = '0;
                n_comps      = '0;
                n_comp_phase = 1'b0;
                n_i          = '0;
                if (CW'(r_a) < CW'(w_n)) begin
                    // start vertex is marked and pushed
                    n_visited[w_a_v] = 1'b1;
                    stk_we           = 1'b1;
                    stk_waddr        = '0;
                    stk_wdata        = w_a_v;
                    n_sp             = NW'(1);
                    n_reach          = NW'(1);
                    n_state          = S_POP;
                end else if (r_dir) begin
                    n_state = S_FIN;
                end else begin
                    n_comp_phase = 1'b1;
                    n_state      = S_COMP;
                end
            end

            S_POP: begin
                if (r_sp == '0) begin
                    // walk finished
                    if (!r_comp_phase) begin
                        if (r_dir) begin
                            n_state = S_FIN;
                        end else begin
                            n_visited    = '0;
                            n_i          = '0;
                            n_comp_phase = 1'b1;
                            n_state      = S_COMP;
                        end
                    end else if (r_i == w_n_last) begin
                        n_state = S_FIN;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_COMP;
                    end
                end else begin
                    stk_re    = 1'b1;
                    stk_raddr = VW'(r_sp - 1'b1);
                    n_sp      = r_sp - 1'b1;
                    n_state   = S_FETCH;
                end
            end

            S_FETCH: begin
                adj_re    = 1'b1;
                adj_raddr = stk_rdata;
                n_u       = '0;
                n_state   = S_SCAN;
            end

            S_SCAN: begin
                // one neighbor bit per cycle
                if (adj_rdata[r_u] && !r_visited[r_u]) begin
                    n_visited[r_u] = 1'b1;
                    stk_we         = 1'b1;
                    stk_waddr      = r_sp[VW-1:0];
                    stk_wdata      = r_u;
                    n_sp           = r_sp + 1'b1;
                    if (!r_comp_phase) begin
                        n_reach = r_reach + 1'b1;
                    end
                end
                if (r_u == w_n_last) begin
                    n_state = S_POP;
                end else begin
                    n_u = r_u + 1'b1;
                end
            end

            S_COMP: begin
                if (!r_visited[r_i]) begin
                    // new component root
                    n_visited[r_i] = 1'b1;
                    stk_we         = 1'b1;
                    stk_waddr      = '0;
                    stk_wdata      = r_i;
                    n_sp           = NW'(1);
                    n_comps        = r_comps + 1'b1;
                    n_state        = S_POP;
                end else if (r_i == w_n_last) begin
                    n_state = S_FIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            S_FIN: begin
                n_res               = '0;
                n_res.all_reachable = (r_reach == w_n);
                n_res.reached_count = gce_pkg::CNT_W'(r_reach);
                n_res.edge_count    = gce_pkg::EDGE_W'(w_edges);
                if (!r_dir) begin
                    n_res.component_count = gce_pkg::CNT_W'(r_comps);
                    n_res.tree_flag   = (r_comps == NW'(1)) &&
                                        ((SW'(w_edges) + SW'(1)) == SW'(w_n));
                    n_res.forest_flag = ((SW'(w_edges) + SW'(r_comps)) == SW'(w_n));
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_vc         <= gce_pkg::VERTEX_COUNT_RST;
            r_dir        <= 1'b0;
            r_clr_addr   <= '0;
            r_clr_reply  <= 1'b0;
            r_sp         <= '0;
            r_entries    <= '0;
            r_comp_phase <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_reply  <= n_clr_reply;
            r_sp         <= n_sp;
            r_entries    <= n_entries;
            r_comp_phase <= n_comp_phase;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gce_pkg::CFG_VERTEX_COUNT: begin
                        r_vc <= i_cfg_data[gce_pkg::CNT_W-1:0];
                    end
                    gce_pkg::CFG_DIRECTED: begin
                        r_dir <= i_cfg_data[0];
                    end
                    default: begin
                        r_vc <= r_vc;
                    end
                endcase
            end
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_visited  <= n_visited;
        r_u        <= n_u;
        r_i        <= n_i;
        r_reach    <= n_reach;
        r_comps    <= n_comps;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

`ifndef SYNTHESIS
    // stack never grows past the store
    a_sp_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= NW'(MAX_VERTICES))
        else $error("walk stack depth beyond store size");

    // during the reach walk every mark is counted exactly once
    a_reach_marks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_POP || r_state == S_FETCH || r_state == S_SCAN) && !r_comp_phase)
        |-> ($countones(r_visited) == int'(r_reach)))
        else $error("reached count differs from visited map");

    // a stacked vertex is always a visited one
    a_sp_marks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_FETCH || r_state == S_SCAN)
        |-> (int'(r_sp) <= $countones(r_visited)))
        else $error("stack holds more vertices than were marked");

    // entry count only steps up by one or clears
    a_entries_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entries != $past(r_entries))
        |-> (r_entries == $past(r_entries) + 1'b1 || r_entries == '0))
        else $error("adjacency entry count jumped");
`endif

endmodule
